// File: rtl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and constants of the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int unsigned SLOT_BITS = 10;
  localparam int unsigned SLOTS     = 1 << SLOT_BITS;
  localparam int unsigned GEN_BITS  = 16;
  localparam int unsigned CNT_BITS  = SLOT_BITS + 1;
  localparam int unsigned EPOCH_BITS = 64;

  localparam logic [GEN_BITS-1:0] GEN_MAX = '1;
  localparam logic [GEN_BITS-1:0] GEN_ONE = GEN_BITS'(1);

  // Command codes.
  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_DESTROY = 3'd1;
  localparam logic [2:0] CMD_ALIVE   = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_FREEZE  = 3'd4;
  localparam logic [2:0] CMD_RELEASE = 3'd5;

  typedef struct packed {
    logic [2:0]            cmd;
    logic                  handle_valid;
    logic [SLOT_BITS-1:0]  handle_slot;
    logic [GEN_BITS-1:0]   handle_gen;
    logic [EPOCH_BITS-1:0] epoch_in;
  } in_item_t;

  typedef struct packed {
    logic                  ok;
    logic [SLOT_BITS-1:0]  out_slot;
    logic [GEN_BITS-1:0]   out_gen;
    logic [EPOCH_BITS-1:0] epoch_out;
    logic [CNT_BITS-1:0]   live_count;
  } out_item_t;

  // Slot table entry: alive, retired, generation.
  typedef struct packed {
    logic                alive;
    logic                retired;
    logic [GEN_BITS-1:0] gen;
  } slot_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CLR_READ,
    ST_CLR_WAIT,
    ST_OUT
  } state_t;

endpackage

// File: rtl/generational_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator_core
// Generational handle allocator over a slot table and a LIFO free stack.
// ----------------------------------------------------------------------------
// Channel  Ports                      Direction  Payload
// input    in_valid/in_ready/in_data  in         gsa_pkg::in_item_t
// result   out_valid/out_ready/out_data out      gsa_pkg::out_item_t
//
// Steps from acceptance to result: freeze, release, create of a fresh slot,
// unused codes and commands refused while frozen go straight to the result;
// destroy and is-alive read the table first; create from the free stack
// reads the stack, then the table. Clear reads and updates each used slot
// in turn, from the highest down.
// Reset clears the control registers; the alive and retired flags of slots
// beyond the used count are never read, so no clearing pass is needed.
// A new transaction is accepted once the previous result has been taken.
// ----------------------------------------------------------------------------
module generational_slot_allocator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gsa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gsa_pkg::out_item_t out_data
);

  localparam int unsigned SB = gsa_pkg::SLOT_BITS;
  localparam int unsigned GB = gsa_pkg::GEN_BITS;
  localparam int unsigned CB = gsa_pkg::CNT_BITS;
  localparam int unsigned EB = gsa_pkg::EPOCH_BITS;
  localparam int unsigned EW = GB + 2;

  gsa_pkg::state_t   state_r, state_nxt;
  gsa_pkg::in_item_t item_r, item_nxt;
  gsa_pkg::out_item_t res_r, res_nxt;
  logic [CB-1:0]     free_depth_r, free_depth_nxt;
  logic [CB-1:0]     used_r, used_nxt;
  logic [CB-1:0]     live_r, live_nxt;
  logic              frozen_r, frozen_nxt;
  logic [EB-1:0]     epoch_r, epoch_nxt;
  logic [CB-1:0]     walk_r, walk_nxt;

  // Slot table port.
  logic              tab_we;
  logic [SB-1:0]     tab_waddr, tab_raddr;
  gsa_pkg::slot_entry_t tab_wdata, tab_rdata;
  logic [EW-1:0]     tab_rraw;

  // Free stack port.
  logic              stk_we;
  logic [SB-1:0]     stk_waddr, stk_raddr;
  logic [SB-1:0]     stk_wdata, stk_rdata;

  gsa_ram #(.ADDR_BITS(SB), .DATA_BITS(EW)) u_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rraw)
  );
  assign tab_rdata = gsa_pkg::slot_entry_t'(tab_rraw);

  gsa_ram #(.ADDR_BITS(SB), .DATA_BITS(SB)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  logic [SB-1:0] pop_idx;
  logic [SB-1:0] walk_slot;
  logic          handle_ok;
  assign pop_idx   = SB'(free_depth_r - CB'(1));
  assign walk_slot = SB'(walk_r - CB'(1));
  assign in_ready  = (state_r == gsa_pkg::ST_IDLE);
  assign out_valid = (state_r == gsa_pkg::ST_OUT);
  assign out_data  = res_r;

  // Handle check against the entry read from the table.
  assign handle_ok = item_r.handle_valid && (CB'(item_r.handle_slot) < used_r) &&
                     tab_rdata.alive && !tab_rdata.retired &&
                     (tab_rdata.gen == item_r.handle_gen);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gsa_pkg::ST_IDLE;
      free_depth_r <= '0;
      used_r       <= '0;
      live_r       <= '0;
      frozen_r     <= 1'b0;
      epoch_r      <= '0;
      walk_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      free_depth_r <= free_depth_nxt;
      used_r       <= used_nxt;
      live_r       <= live_nxt;
      frozen_r     <= frozen_nxt;
      epoch_r      <= epoch_nxt;
      walk_r       <= walk_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  // Sequencer: next state, memory accesses and result.
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    res_nxt        = res_r;
    free_depth_nxt = free_depth_r;
    used_nxt       = used_r;
    live_nxt       = live_r;
    frozen_nxt     = frozen_r;
    epoch_nxt      = epoch_r;
    walk_nxt       = walk_r;
    tab_we         = 1'b0;
    tab_waddr      = item_r.handle_slot;
    tab_wdata      = tab_rdata;
    tab_raddr      = in_data.handle_slot;
    stk_we         = 1'b0;
    stk_waddr      = SB'(free_depth_r);
    stk_wdata      = item_r.handle_slot;
    stk_raddr      = pop_idx;
    case (state_r)
      gsa_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          res_nxt.live_count = live_r;
          state_nxt = gsa_pkg::ST_OUT;
          case (in_data.cmd)
            gsa_pkg::CMD_CREATE: begin
              if (!frozen_r) begin
                if (free_depth_r != '0) begin
                  free_depth_nxt = free_depth_r - CB'(1);
                  state_nxt = gsa_pkg::ST_READ;
                end else if (used_r < CB'(gsa_pkg::SLOTS)) begin
                  tab_we    = 1'b1;
                  tab_waddr = SB'(used_r);
                  tab_wdata = '{alive: 1'b1, retired: 1'b0, gen: gsa_pkg::GEN_ONE};
                  used_nxt  = used_r + CB'(1);
                  live_nxt  = live_r + CB'(1);
                  res_nxt.ok = 1'b1;
                  res_nxt.out_slot = SB'(used_r);
                  res_nxt.out_gen  = gsa_pkg::GEN_ONE;
                  res_nxt.live_count = live_r + CB'(1);
                end
              end
            end
            gsa_pkg::CMD_DESTROY: begin
              if (!frozen_r) begin
                state_nxt = gsa_pkg::ST_READ;
              end
            end
            gsa_pkg::CMD_ALIVE: begin
              state_nxt = gsa_pkg::ST_READ;
            end
            gsa_pkg::CMD_CLEAR: begin
              if (!frozen_r) begin
                free_depth_nxt = '0;
                walk_nxt  = used_r;
                state_nxt = gsa_pkg::ST_CLR_READ;
              end
            end
            gsa_pkg::CMD_FREEZE: begin
              if (!frozen_r && (epoch_r != '1)) begin
                epoch_nxt  = epoch_r + EB'(1);
                frozen_nxt = 1'b1;
                res_nxt.ok = 1'b1;
                res_nxt.epoch_out = epoch_r + EB'(1);
              end
            end
            gsa_pkg::CMD_RELEASE: begin
              if (frozen_r && (in_data.epoch_in == epoch_r)) begin
                frozen_nxt = 1'b0;
                res_nxt.ok = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      gsa_pkg::ST_READ: begin
        state_nxt = gsa_pkg::ST_OUT;
        case (item_r.cmd)
          gsa_pkg::CMD_CREATE: begin
            // Stack entry is now on the read port; fetch its table entry first.
            item_nxt.cmd = gsa_pkg::CMD_CLEAR;
            item_nxt.handle_slot = stk_rdata;
            tab_raddr = stk_rdata;
            state_nxt = gsa_pkg::ST_READ;
          end
          gsa_pkg::CMD_CLEAR: begin
            // Second half of a pop: mark the slot alive.
            tab_we    = 1'b1;
            tab_wdata.alive = 1'b1;
            live_nxt  = live_r + CB'(1);
            res_nxt.ok = 1'b1;
            res_nxt.out_slot = item_r.handle_slot;
            res_nxt.out_gen  = tab_rdata.gen;
            res_nxt.live_count = live_r + CB'(1);
          end
          gsa_pkg::CMD_DESTROY: begin
            if (handle_ok) begin
              tab_we = 1'b1;
              tab_wdata.alive = 1'b0;
              if (tab_rdata.gen == gsa_pkg::GEN_MAX) begin
                tab_wdata.retired = 1'b1;
              end else begin
                tab_wdata.gen = tab_rdata.gen + GB'(1);
                stk_we = (free_depth_r < CB'(gsa_pkg::SLOTS));
                free_depth_nxt = stk_we ? free_depth_r + CB'(1) : free_depth_r;
              end
              live_nxt = (live_r != '0) ? live_r - CB'(1) : live_r;
              res_nxt.ok = 1'b1;
              res_nxt.live_count = live_nxt;
            end
          end
          default: begin
            res_nxt.ok = handle_ok;
          end
        endcase
      end
      gsa_pkg::ST_CLR_READ: begin
        if (walk_r == '0) begin
          live_nxt = '0;
          res_nxt.ok = 1'b1;
          res_nxt.live_count = '0;
          state_nxt = gsa_pkg::ST_OUT;
        end else begin
          tab_raddr = walk_slot;
          state_nxt = gsa_pkg::ST_CLR_WAIT;
        end
      end
      gsa_pkg::ST_CLR_WAIT: begin
        // Kill a live entry, bump or retire it, push when not retired.
        tab_waddr = walk_slot;
        tab_we    = tab_rdata.alive;
        tab_wdata.alive = 1'b0;
        if (tab_rdata.alive) begin
          if (tab_rdata.gen == gsa_pkg::GEN_MAX) begin
            tab_wdata.retired = 1'b1;
          end else begin
            tab_wdata.gen = tab_rdata.gen + GB'(1);
          end
        end
        stk_wdata = walk_slot;
        stk_we = !tab_wdata.retired && (free_depth_r < CB'(gsa_pkg::SLOTS));
        free_depth_nxt = stk_we ? free_depth_r + CB'(1) : free_depth_r;
        walk_nxt  = walk_r - CB'(1);
        state_nxt = gsa_pkg::ST_CLR_READ;
      end
      gsa_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = gsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/gsa_ram.sv
// ----------------------------------------------------------------------------
// gsa_ram
// Generic single-port-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module gsa_ram #(
  parameter int unsigned ADDR_BITS = 10,
  parameter int unsigned DATA_BITS = 18
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/sv/generational_slot_allocator_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_slot_allocator_core_checker
// Watches both channels of the allocator and keeps a shadow copy of the slot
// table, free stack, counters and epoch lock. For every accepted command it
// works out the expected result and compares each result transaction with
// the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module generational_slot_allocator_core_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  gsa_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  gsa_pkg::out_item_t out_data,
  output int                 errors,
  output int                 pending
);

  localparam int unsigned SLOTS      = gsa_pkg::SLOTS;
  localparam int unsigned SLOT_BITS  = gsa_pkg::SLOT_BITS;
  localparam int unsigned GEN_BITS   = gsa_pkg::GEN_BITS;
  localparam int unsigned CNT_BITS   = gsa_pkg::CNT_BITS;
  localparam int unsigned EPOCH_BITS = gsa_pkg::EPOCH_BITS;

  // Shadow state of the allocator.
  logic                  alive_q   [SLOTS];
  logic                  retired_q [SLOTS];
  logic [GEN_BITS-1:0]   gen_q     [SLOTS];
  logic [SLOT_BITS-1:0]  free_q    [SLOTS];
  logic [CNT_BITS-1:0]   free_depth;
  logic [CNT_BITS-1:0]   used_slots;
  logic [CNT_BITS-1:0]   live_total;
  logic                  frozen;
  logic [EPOCH_BITS-1:0] epoch_ctr;

  gsa_pkg::out_item_t expected_results[$];

  function automatic logic handle_is_live(gsa_pkg::in_item_t c);
    if (!c.handle_valid || CNT_BITS'(c.handle_slot) >= used_slots) return 1'b0;
    return alive_q[c.handle_slot] && !retired_q[c.handle_slot] &&
           gen_q[c.handle_slot] == c.handle_gen;
  endfunction

  function automatic void push_free(logic [SLOT_BITS-1:0] s);
    if (free_depth < CNT_BITS'(SLOTS)) begin
      free_q[free_depth[SLOT_BITS-1:0]] = s;
      free_depth = free_depth + CNT_BITS'(1);
    end
  endfunction

  // Apply one command to the shadow state and return the result it gives.
  function automatic gsa_pkg::out_item_t apply_command(gsa_pkg::in_item_t c);
    gsa_pkg::out_item_t r;
    logic [SLOT_BITS-1:0] s;
    r = '0;
    case (c.cmd)
      gsa_pkg::CMD_CREATE: begin
        if (!frozen) begin
          if (free_depth > 0) begin
            free_depth = free_depth - CNT_BITS'(1);
            s = free_q[free_depth[SLOT_BITS-1:0]];
            alive_q[s] = 1'b1;
            live_total = live_total + CNT_BITS'(1);
            r.ok = 1'b1;
            r.out_slot = s;
            r.out_gen = gen_q[s];
          end else if (used_slots < CNT_BITS'(SLOTS)) begin
            s = used_slots[SLOT_BITS-1:0];
            used_slots = used_slots + CNT_BITS'(1);
            gen_q[s] = gsa_pkg::GEN_ONE;
            alive_q[s] = 1'b1;
            retired_q[s] = 1'b0;
            live_total = live_total + CNT_BITS'(1);
            r.ok = 1'b1;
            r.out_slot = s;
            r.out_gen = gsa_pkg::GEN_ONE;
          end
        end
      end
      gsa_pkg::CMD_DESTROY: begin
        if (!frozen && handle_is_live(c)) begin
          s = c.handle_slot;
          alive_q[s] = 1'b0;
          if (live_total > 0) live_total = live_total - CNT_BITS'(1);
          if (gen_q[s] == gsa_pkg::GEN_MAX) begin
            retired_q[s] = 1'b1;
          end else begin
            gen_q[s] = gen_q[s] + GEN_BITS'(1);
            push_free(s);
          end
          r.ok = 1'b1;
        end
      end
      gsa_pkg::CMD_ALIVE: r.ok = handle_is_live(c);
      gsa_pkg::CMD_CLEAR: begin
        if (!frozen) begin
          free_depth = '0;
          for (int i = int'(used_slots); i > 0; i--) begin
            s = SLOT_BITS'(i - 1);
            if (alive_q[s]) begin
              alive_q[s] = 1'b0;
              if (gen_q[s] == gsa_pkg::GEN_MAX) retired_q[s] = 1'b1;
              else gen_q[s] = gen_q[s] + GEN_BITS'(1);
            end
            if (!retired_q[s]) push_free(s);
          end
          live_total = '0;
          r.ok = 1'b1;
        end
      end
      gsa_pkg::CMD_FREEZE: begin
        if (!frozen && epoch_ctr != '1) begin
          epoch_ctr = epoch_ctr + EPOCH_BITS'(1);
          frozen = 1'b1;
          r.ok = 1'b1;
          r.epoch_out = epoch_ctr;
        end
      end
      gsa_pkg::CMD_RELEASE: begin
        if (frozen && c.epoch_in == epoch_ctr) begin
          frozen = 1'b0;
          r.ok = 1'b1;
        end
      end
      default: r.ok = 1'b0;
    endcase
    r.live_count = live_total;
    return r;
  endfunction

  // Compare results first, then predict for a newly accepted command.
  always @(posedge clk) begin
    gsa_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        alive_q[i] = 1'b0;
        retired_q[i] = 1'b0;
      end
      free_depth = '0;
      used_slots = '0;
      live_total = '0;
      frozen     = 1'b0;
      epoch_ctr  = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
            errors++;
          end
          if (out_data.out_slot !== want.out_slot) begin
            $error("out_slot: expected %0d, got %0d", want.out_slot, out_data.out_slot);
            errors++;
          end
          if (out_data.out_gen !== want.out_gen) begin
            $error("out_gen: expected %0d, got %0d", want.out_gen, out_data.out_gen);
            errors++;
          end
          if (out_data.epoch_out !== want.epoch_out) begin
            $error("epoch_out: expected %0d, got %0d", want.epoch_out, out_data.epoch_out);
            errors++;
          end
          if (out_data.live_count !== want.live_count) begin
            $error("live_count: expected %0d, got %0d", want.live_count,
                   out_data.live_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), apply_command(in_data));
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: tb/sv/generational_slot_allocator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_slot_allocator_core_test
// Drives command transactions into the allocator with random gaps and result
// stalls. It runs directed corner cases, fills the table past full, clears
// it, and finishes with a random mix of well-formed and broken commands.
// The checker judges every result.
// ----------------------------------------------------------------------------
module generational_slot_allocator_core_test;

  localparam int unsigned SLOTS      = gsa_pkg::SLOTS;
  localparam int unsigned SLOT_BITS  = gsa_pkg::SLOT_BITS;
  localparam int unsigned GEN_BITS   = gsa_pkg::GEN_BITS;
  localparam int unsigned EPOCH_BITS = gsa_pkg::EPOCH_BITS;

  // Command codes the block does not define.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 4000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  gsa_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  gsa_pkg::out_item_t out_data;
  int                 errors;
  int                 pending;

  // Stimulus steering.
  logic      quiet = 1'b1;
  logic      long_hold_req = 1'b0;
  logic      long_hold_done = 1'b0;
  int        hold_left = 0;
  int        rx_gap = 0;
  logic      rx_calm = 1'b0;
  logic      tx_calm = 1'b0;
  int        cycles = 0;

  // Handles handed out by the block, and the last epoch granted by freeze.
  logic [SLOT_BITS+GEN_BITS-1:0] handle_pool[$];
  logic [EPOCH_BITS-1:0]         last_epoch = '0;
  logic [2:0]                    cmds_in_flight[$];

  generational_slot_allocator_core dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  generational_slot_allocator_core_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .errors, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("generational_slot_allocator_core_test failed");
      $finish;
    end
  end

  // Learn handles and epochs from results so that later commands hit live state.
  always @(posedge clk) begin
    logic [2:0] c;
    if (rst_n) begin
      if (out_valid && out_ready && cmds_in_flight.size() > 0) begin
        c = cmds_in_flight.pop_front();
        if (c == gsa_pkg::CMD_CREATE && out_data.ok) begin
          handle_pool.insert(handle_pool.size(), {out_data.out_slot, out_data.out_gen});
          if (handle_pool.size() > 64) void'(handle_pool.pop_front());
        end
        if (c == gsa_pkg::CMD_FREEZE && out_data.ok) last_epoch = out_data.epoch_out;
      end
      if (in_valid && in_ready) cmds_in_flight.insert(cmds_in_flight.size(), in_data.cmd);
    end
  end

  // Result side: short and long stalls, calm stretches, one long hold-off.
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      out_ready <= 1'b0;
      hold_left <= 400;
      long_hold_done <= 1'b1;
    end else if (quiet || rx_calm) begin
      out_ready <= 1'b1;
      if ($urandom_range(199) == 0) rx_calm <= 1'b0;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
      r = $urandom_range(99);
      if (r < 20) rx_gap <= $urandom_range(3, 1);
      else if (r < 23) rx_gap <= $urandom_range(60, 15);
      else if (r < 24) rx_calm <= 1'b1;
    end
  end

  function automatic gsa_pkg::in_item_t make_cmd(logic [2:0] c, logic v,
                                                 logic [SLOT_BITS-1:0] s,
                                                 logic [GEN_BITS-1:0] g,
                                                 logic [EPOCH_BITS-1:0] e);
    gsa_pkg::in_item_t t;
    t.cmd = c;
    t.handle_valid = v;
    t.handle_slot = s;
    t.handle_gen = g;
    t.epoch_in = e;
    return t;
  endfunction

  function automatic logic [EPOCH_BITS-1:0] rand_epoch();
    return {$urandom(), $urandom()};
  endfunction

  // A command of the given code with every other field random.
  function automatic gsa_pkg::in_item_t rand_cmd(logic [2:0] c);
    return make_cmd(c, 1'($urandom()), SLOT_BITS'($urandom()), GEN_BITS'($urandom()),
                    rand_epoch());
  endfunction

  // Offer one transaction and hold it until accepted.
  task automatic send(gsa_pkg::in_item_t t);
    int gap;
    gap = 0;
    if (!quiet && !tx_calm) begin
      if ($urandom_range(99) < 25) gap = $urandom_range(3, 1);
      else if ($urandom_range(99) < 3) gap = $urandom_range(50, 10);
    end
    if ($urandom_range(149) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    while (pending != 0 || cmds_in_flight.size() != 0) @(posedge clk);
  endtask

  // A handle that is usually one the block handed out, sometimes random.
  function automatic gsa_pkg::in_item_t pick_handle(logic [2:0] c);
    gsa_pkg::in_item_t t;
    t = make_cmd(c, 1'b1, SLOT_BITS'($urandom()), GEN_BITS'($urandom()), rand_epoch());
    if (handle_pool.size() > 0 && $urandom_range(99) < 80)
      {t.handle_slot, t.handle_gen} =
        handle_pool[$urandom_range(handle_pool.size() - 1)];
    else if ($urandom_range(1) == 0)
      t.handle_gen = GEN_BITS'($urandom_range(3));
    if ($urandom_range(99) < 5) t.handle_valid = 1'b0;
    return t;
  endfunction

  initial begin
    gsa_pkg::in_item_t t;
    logic [SLOT_BITS+GEN_BITS-1:0] h;
    int r;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    quiet = 1'b0;

    // Directed corner cases.
    send(make_cmd(gsa_pkg::CMD_ALIVE, 1'b1, '1, '1, '1));
    send(make_cmd(gsa_pkg::CMD_DESTROY, 1'b0, '1, '0, '0));
    send(make_cmd(gsa_pkg::CMD_RELEASE, 1'b0, '0, '0, '0));
    send(make_cmd(gsa_pkg::CMD_FREEZE, 1'b0, '0, '0, '0));
    drain();
    send(make_cmd(gsa_pkg::CMD_FREEZE, 1'b0, '0, '0, '0));
    send(make_cmd(gsa_pkg::CMD_CREATE, 1'b1, '1, '1, '1));
    send(make_cmd(gsa_pkg::CMD_DESTROY, 1'b1, SLOT_BITS'(1), gsa_pkg::GEN_ONE, '0));
    send(make_cmd(gsa_pkg::CMD_CLEAR, 1'b0, '0, '0, '0));
    send(make_cmd(gsa_pkg::CMD_ALIVE, 1'b1, SLOT_BITS'(1), gsa_pkg::GEN_ONE, '0));
    send(make_cmd(gsa_pkg::CMD_RELEASE, 1'b0, '0, '0, last_epoch + EPOCH_BITS'(1)));
    send(make_cmd(gsa_pkg::CMD_RELEASE, 1'b0, '0, '0, last_epoch));
    send(make_cmd(CMD_SPARE_LO, 1'b1, '1, '1, '1));
    send(make_cmd(CMD_SPARE_HI, 1'b1, '0, '0, '0));
    send(make_cmd(gsa_pkg::CMD_CREATE, 1'b0, '0, '0, '0));
    drain();
    h = handle_pool[$];
    send(make_cmd(gsa_pkg::CMD_ALIVE, 1'b0, h[GEN_BITS +: SLOT_BITS], h[GEN_BITS-1:0],
                  '0));
    send(make_cmd(gsa_pkg::CMD_ALIVE, 1'b1, h[GEN_BITS +: SLOT_BITS],
                  h[GEN_BITS-1:0] + GEN_BITS'(1), '0));
    send(make_cmd(gsa_pkg::CMD_ALIVE, 1'b1, h[GEN_BITS +: SLOT_BITS], h[GEN_BITS-1:0],
                  '0));
    send(make_cmd(gsa_pkg::CMD_DESTROY, 1'b1, h[GEN_BITS +: SLOT_BITS], h[GEN_BITS-1:0],
                  '0));
    send(make_cmd(gsa_pkg::CMD_CREATE, 1'b0, '0, '0, '0));
    send(make_cmd(gsa_pkg::CMD_CLEAR, 1'b0, '0, '0, '0));

    // Fill the table past full, then clear it.
    for (int i = 0; i < SLOTS + 2; i++) send(make_cmd(gsa_pkg::CMD_CREATE, 1'b0, '0, '0, '0));
    send(make_cmd(gsa_pkg::CMD_CLEAR, 1'b0, '0, '0, '0));

    // Random mix; partway through the receiver holds off for a long stretch.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) long_hold_req = 1'b1;
      r = $urandom_range(99);
      if (r < 32) t = rand_cmd(gsa_pkg::CMD_CREATE);
      else if (r < 57) t = pick_handle(gsa_pkg::CMD_DESTROY);
      else if (r < 77) t = pick_handle(gsa_pkg::CMD_ALIVE);
      else if (r < 79) t = rand_cmd(gsa_pkg::CMD_CLEAR);
      else if (r < 87) t = rand_cmd(gsa_pkg::CMD_FREEZE);
      else if (r < 97) begin
        t = rand_cmd(gsa_pkg::CMD_RELEASE);
        if ($urandom_range(99) < 75) t.epoch_in = last_epoch;
      end else t = rand_cmd(($urandom_range(1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI);
      send(t);
    end
    in_valid <= 1'b0;

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("generational_slot_allocator_core_test passed");
    end else begin
      $display("generational_slot_allocator_core_test failed");
    end
    $finish;
  end

endmodule
